[src/n2a_pkg.sv]
// ----------------------------------------------------------------------------
// n2a_pkg: shared types and constants of the number to ASCII formatter
// Holds the conversion codes, the commands and status that pass between the
// controller and the datapath, and the digit-to-character lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package n2a_pkg;

  // Conversion codes carried on in_cmd
  localparam logic [3:0] CMD_LITERAL = 4'd0;
  localparam logic [3:0] CMD_CHAR    = 4'd1;
  localparam logic [3:0] CMD_SDEC    = 4'd2;
  localparam logic [3:0] CMD_UDEC    = 4'd3;
  localparam logic [3:0] CMD_HEXL    = 4'd4;
  localparam logic [3:0] CMD_HEXU    = 4'd5;
  localparam logic [3:0] CMD_PTR     = 4'd6;
  localparam logic [3:0] CMD_PCT     = 4'd7;

  // Reciprocal of ten: x / 10 == (x * DIV10_MAGIC) >> DIV10_SHIFT for any 32-bit x
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  // Number of hex digits the digit stack must hold (64-bit pointer)
  localparam int STACK_DEPTH = 16;

  // ASCII characters that the conversions emit besides digits
  localparam logic [7:0] ASCII_PCT   = 8'h25;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_X     = 8'h78;

  // Source of the character that an emit command places on the output
  typedef enum logic [2:0] {
    SEL_IN_BYTE,
    SEL_PCT,
    SEL_MINUS,
    SEL_ZERO,
    SEL_X,
    SEL_DIGIT
  } char_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      load;    // capture the value to convert
    logic      mul;     // form the reciprocal product for a decimal digit
    logic      div;     // push a decimal digit and keep the quotient
    logic      hex;     // push a hex digit and shift the value
    logic      emit;    // drive one character onto the output
    char_sel_t sel;
    logic      upper;   // upper-case hex letters
    logic      last;    // character ends the conversion
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_neg;      // sign bit of the low word on the input
    logic dec_done;    // quotient of this decimal step is zero
    logic hex_done;    // value after this hex step is zero
    logic last_digit;  // one digit left on the stack
  } dp_stat_t;

  // Map a digit 0..15 to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'h0, d};
    end else if (upper) begin
      c = 8'h41 + {4'h0, d} - 8'd10;
    end else begin
      c = 8'h61 + {4'h0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/n2a_ctrl.sv]
// ----------------------------------------------------------------------------
// n2a_ctrl: conversion sequencer
// Decodes the request; emits a single character directly, or steps the
// datapath through digit extraction, then emission of prefixes and digits.
// ----------------------------------------------------------------------------
`default_nettype none

module n2a_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [3:0]        in_cmd,
  input  wire n2a_pkg::dp_stat_t stat,
  output logic                   busy,
  output n2a_pkg::dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_HEX,
    ST_MINUS,
    ST_ZERO,
    ST_X,
    ST_DIG
  } state_t;

  state_t state_r, state_nxt;
  logic   neg_r, neg_nxt;
  logic   ptr_r, ptr_nxt;
  logic   upper_r, upper_nxt;
  state_t after_conv;

  // First state after the digits are on the stack
  always_comb begin
    if (neg_r) begin
      after_conv = ST_MINUS;
    end else if (ptr_r) begin
      after_conv = ST_ZERO;
    end else begin
      after_conv = ST_DIG;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    neg_nxt   = neg_r;
    ptr_nxt   = ptr_r;
    upper_nxt = upper_r;
    cmd       = '0;
    cmd.sel   = n2a_pkg::SEL_IN_BYTE;
    cmd.upper = upper_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          neg_nxt   = 1'b0;
          ptr_nxt   = 1'b0;
          upper_nxt = 1'b0;
          case (in_cmd)
            n2a_pkg::CMD_LITERAL, n2a_pkg::CMD_CHAR: begin
              cmd.emit = 1'b1;
              cmd.sel  = n2a_pkg::SEL_IN_BYTE;
              cmd.last = 1'b1;
            end
            n2a_pkg::CMD_PCT: begin
              cmd.emit = 1'b1;
              cmd.sel  = n2a_pkg::SEL_PCT;
              cmd.last = 1'b1;
            end
            n2a_pkg::CMD_SDEC: begin
              cmd.load  = 1'b1;
              neg_nxt   = stat.in_neg;
              state_nxt = ST_MUL;
            end
            n2a_pkg::CMD_UDEC: begin
              cmd.load  = 1'b1;
              state_nxt = ST_MUL;
            end
            n2a_pkg::CMD_HEXL: begin
              cmd.load  = 1'b1;
              state_nxt = ST_HEX;
            end
            n2a_pkg::CMD_HEXU: begin
              cmd.load  = 1'b1;
              upper_nxt = 1'b1;
              state_nxt = ST_HEX;
            end
            n2a_pkg::CMD_PTR: begin
              cmd.load  = 1'b1;
              ptr_nxt   = 1'b1;
              state_nxt = ST_HEX;
            end
            default: begin
              // unknown conversion: nothing to print
            end
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = stat.dec_done ? after_conv : ST_MUL;
      end
      ST_HEX: begin
        cmd.hex   = 1'b1;
        state_nxt = stat.hex_done ? after_conv : ST_HEX;
      end
      ST_MINUS: begin
        cmd.emit  = 1'b1;
        cmd.sel   = n2a_pkg::SEL_MINUS;
        state_nxt = ST_DIG;
      end
      ST_ZERO: begin
        cmd.emit  = 1'b1;
        cmd.sel   = n2a_pkg::SEL_ZERO;
        state_nxt = ST_X;
      end
      ST_X: begin
        cmd.emit  = 1'b1;
        cmd.sel   = n2a_pkg::SEL_X;
        state_nxt = ST_DIG;
      end
      ST_DIG: begin
        cmd.emit = 1'b1;
        cmd.sel  = n2a_pkg::SEL_DIGIT;
        cmd.last = stat.last_digit;
        if (stat.last_digit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and conversion flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      neg_r   <= 1'b0;
      ptr_r   <= 1'b0;
      upper_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      neg_r   <= neg_nxt;
      ptr_r   <= ptr_nxt;
      upper_r <= upper_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

[src/n2a_dpath.sv]
// ----------------------------------------------------------------------------
// n2a_dpath: digit extraction and character output
// Splits the value into digits, least significant first, onto a nibble stack,
// then pops them most significant first through the character lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module n2a_dpath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [3:0]       in_cmd,
  input  wire logic [63:0]      in_value,
  input  wire n2a_pkg::dp_cmd_t cmd,
  output n2a_pkg::dp_stat_t     stat,
  output logic                  out_valid,
  output logic [7:0]            out_ascii_char,
  output logic                  out_last_char
);

  localparam int CntW = $clog2(n2a_pkg::STACK_DEPTH + 1);

  logic [63:0] val_r, val_nxt;
  logic [63:0] prod_r;
  logic [n2a_pkg::STACK_DEPTH-1:0][3:0] stk_r;
  logic [CntW-1:0] cnt_r;
  logic        out_valid_r;
  logic [7:0]  out_char_r;
  logic        out_last_r;

  logic [31:0] low32;
  logic [28:0] quot;
  logic [31:0] rem32;
  logic [3:0]  push_digit;
  logic        push;
  logic [7:0]  char_sel;

  assign low32 = in_value[31:0];

  // Value to convert: magnitude for negative decimal, full word for pointer
  always_comb begin
    case (in_cmd)
      n2a_pkg::CMD_SDEC: val_nxt = low32[31] ? {32'h0, (~low32) + 32'd1} : {32'h0, low32};
      n2a_pkg::CMD_PTR:  val_nxt = in_value;
      default:           val_nxt = {32'h0, low32};
    endcase
  end

  // Divide by ten from the registered reciprocal product
  assign quot  = prod_r[63:n2a_pkg::DIV10_SHIFT];
  assign rem32 = val_r[31:0] - {quot, 3'b000} - {2'b00, quot, 1'b0};

  assign push       = cmd.div | cmd.hex;
  assign push_digit = cmd.div ? rem32[3:0] : val_r[3:0];

  // Status back to the controller
  assign stat.in_neg     = low32[31];
  assign stat.dec_done   = (quot == 29'd0);
  assign stat.hex_done   = (val_r[63:4] == 60'd0);
  assign stat.last_digit = (cnt_r == CntW'(1));

  // Pick the character to emit
  always_comb begin
    case (cmd.sel)
      n2a_pkg::SEL_IN_BYTE: char_sel = in_value[7:0];
      n2a_pkg::SEL_PCT:     char_sel = n2a_pkg::ASCII_PCT;
      n2a_pkg::SEL_MINUS:   char_sel = n2a_pkg::ASCII_MINUS;
      n2a_pkg::SEL_ZERO:    char_sel = n2a_pkg::ASCII_ZERO;
      n2a_pkg::SEL_X:       char_sel = n2a_pkg::ASCII_X;
      n2a_pkg::SEL_DIGIT:   char_sel = n2a_pkg::digit_char(stk_r[0], cmd.upper);
      default:              char_sel = in_value[7:0];
    endcase
  end

  // Value, product and digit stack payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= val_nxt;
    end else if (cmd.div) begin
      val_r <= {35'h0, quot};
    end else if (cmd.hex) begin
      val_r <= {4'h0, val_r[63:4]};
    end
    if (cmd.mul) begin
      prod_r <= val_r[31:0] * n2a_pkg::DIV10_MAGIC;
    end
    if (push) begin
      stk_r <= {stk_r[n2a_pkg::STACK_DEPTH-2:0], push_digit};
    end else if (cmd.emit && cmd.sel == n2a_pkg::SEL_DIGIT) begin
      stk_r <= {4'h0, stk_r[n2a_pkg::STACK_DEPTH-1:1]};
    end
    out_char_r <= char_sel;
    out_last_r <= cmd.last;
  end

  // Stack depth and output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (push) begin
        cnt_r <= cnt_r + CntW'(1);
      end else if (cmd.emit && cmd.sel == n2a_pkg::SEL_DIGIT) begin
        cnt_r <= cnt_r - CntW'(1);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_char_r;
  assign out_last_char  = out_last_r;

  // Stack never underflows or overflows, the last digit empties it, and load never coincides with emit
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.sel == n2a_pkg::SEL_DIGIT) |-> (cnt_r != '0))
    else $error("digit popped from empty stack");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != CntW'(n2a_pkg::STACK_DEPTH)))
    else $error("digit pushed onto full stack");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.sel == n2a_pkg::SEL_DIGIT && cmd.last) |=> (cnt_r == '0))
    else $error("digits left after last character");

  a_load_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.emit)
    else $error("load and emit in the same cycle");

endmodule

`default_nettype wire

[src/number_to_ascii_formatter_top.sv]
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_top: printf-style integer conversion
// Turns a request into its ASCII characters, one per cycle after extraction.
// ----------------------------------------------------------------------------
// Usage:
//   A request (in_cmd, in_value) is taken at a rising edge with start high
//   and busy low. Characters come out on out_ascii_char, each for exactly
//   one cycle with out_valid high; out_last_char marks the final one. The
//   receiver cannot stall, so the block paces the output itself.
// Timing:
//   Literal, %c and %%: busy stays low and the character shows the next
//   cycle, so such requests may come every cycle.
//   Decimal: per digit, a reciprocal multiply and then a correction step
//   that pushes the digit; then an optional '-', then the digits.
//   Hex: one nibble extraction step per digit, then the digits; pointer
//   converts the full 64-bit value and adds "0x" before its digits.
//   The digit stack reverses digit order. An unknown code is taken and
//   prints nothing.
// Reset:
//   rst_n low returns the sequencer to idle and drops any request in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module number_to_ascii_formatter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  in_cmd,
  input  wire logic [63:0] in_value,
  output logic             out_valid,
  output logic [7:0]       out_ascii_char,
  output logic             out_last_char
);

  n2a_pkg::dp_cmd_t  dp_cmd;
  n2a_pkg::dp_stat_t dp_stat;

  // Sequencer
  n2a_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (dp_stat),
    .busy   (busy),
    .cmd    (dp_cmd)
  );

  // Digit datapath and output register
  n2a_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_cmd),
    .in_value       (in_value),
    .cmd            (dp_cmd),
    .stat           (dp_stat),
    .out_valid      (out_valid),
    .out_ascii_char (out_ascii_char),
    .out_last_char  (out_last_char)
  );

endmodule

`default_nettype wire
